>>> rtl/spims_pkg.sv
// ----------------------------------------------------------------------------
// spims_pkg
// Shared types, constants and helpers for the SPI master byte shifter.
// ----------------------------------------------------------------------------
package spims_pkg;

    // Transfer geometry
    localparam int DATA_BITS  = 8;
    localparam int EDGE_W     = 5;
    localparam int DIV_W      = 7;
    localparam int HALF_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [EDGE_W-1:0] EDGE_TOTAL = EDGE_W'(2 * DATA_BITS);
    localparam logic [EDGE_W-1:0] EDGE_LAST  = EDGE_W'(2 * DATA_BITS - 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPI_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LSB_FIRST    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPI_MODE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_SELECT = 2'd3;

    // Input command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef struct packed {
        logic                 command;
        logic [DATA_BITS-1:0] tx_byte;
        logic                 miso_bit;
    } in_item_t;

    typedef struct packed {
        logic                 sck_level;
        logic                 mosi_level;
        logic                 busy_res;
        logic                 done_res;
        logic [DATA_BITS-1:0] rx_byte;
    } out_item_t;

    typedef struct packed {
        logic       spi_enable;
        logic       lsb_first;
        logic [1:0] spi_mode;
        logic [2:0] clock_select;
    } cfg_t;

    // Half of the SCK period in ticks, per divider code
    function automatic logic [HALF_W-1:0] half_period(input logic [2:0] sel);
        logic [HALF_W-1:0] h;
        case (sel)
            3'd0:    h = 8'd2;
            3'd1:    h = 8'd8;
            3'd2:    h = 8'd32;
            3'd3:    h = 8'd64;
            3'd4:    h = 8'd1;
            3'd5:    h = 8'd4;
            3'd6:    h = 8'd16;
            3'd7:    h = 8'd32;
            default: h = 8'd2;
        endcase
        return h;
    endfunction

    // One shift step; the sampled bit enters at the far end
    function automatic logic [DATA_BITS-1:0] shift_step(
        input logic [DATA_BITS-1:0] value,
        input logic                 bit_in,
        input logic                 lsb
    );
        logic [DATA_BITS-1:0] r;
        if (lsb)
        begin
            r = {bit_in, value[DATA_BITS-1:1]};
        end
        else
        begin
            r = {value[DATA_BITS-2:0], bit_in};
        end
        return r;
    endfunction

endpackage

>>> rtl/spims_cfg.sv
// ----------------------------------------------------------------------------
// spims_cfg
// Configuration register file; writes are always taken.
// ----------------------------------------------------------------------------
module spims_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spims_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spims_pkg::CFG_DATA_W-1:0]    cfg_data,
    output spims_pkg::cfg_t                     cfg
);

    spims_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spi_enable   <= 1'b1;
            cfg_reg.lsb_first    <= 1'b0;
            cfg_reg.spi_mode     <= 2'd0;
            cfg_reg.clock_select <= 3'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                spims_pkg::REG_SPI_ENABLE:   cfg_reg.spi_enable   <= cfg_data[0];
                spims_pkg::REG_LSB_FIRST:    cfg_reg.lsb_first    <= cfg_data[0];
                spims_pkg::REG_SPI_MODE:     cfg_reg.spi_mode     <= cfg_data[1:0];
                spims_pkg::REG_CLOCK_SELECT: cfg_reg.clock_select <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/spims_engine.sv
// ----------------------------------------------------------------------------
// spims_engine
// Transfer state and one-tick update: divider, SCK toggling, sample/shift.
// ----------------------------------------------------------------------------
module spims_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  spims_pkg::cfg_t       cfg,
    input  spims_pkg::in_item_t   item,
    output spims_pkg::out_item_t  result
);

    logic [spims_pkg::DATA_BITS-1:0] shift_reg,    shift_next;
    logic [spims_pkg::EDGE_W-1:0]    edge_cnt_reg, edge_cnt_next;
    logic [spims_pkg::DIV_W-1:0]     div_cnt_reg,  div_cnt_next;
    logic                            sck_reg,      sck_next;
    logic                            active_reg,   active_next;
    logic [spims_pkg::DATA_BITS-1:0] rcvd_reg,     rcvd_next;
    logic                            sample_reg,   sample_next;

    logic                         cpol;
    logic                         cpha;
    logic                         done;
    logic [spims_pkg::HALF_W-1:0] half;
    logic [spims_pkg::EDGE_W-1:0] edge_inc;

    assign cpol     = cfg.spi_mode[1];
    assign cpha     = cfg.spi_mode[0];
    assign half     = spims_pkg::half_period(cfg.clock_select);
    assign edge_inc = edge_cnt_reg + spims_pkg::EDGE_W'(1);

    // Next state for one tick
    always_comb
    begin
        shift_next    = shift_reg;
        edge_cnt_next = edge_cnt_reg;
        div_cnt_next  = div_cnt_reg;
        sck_next      = sck_reg;
        active_next   = active_reg;
        rcvd_next     = rcvd_reg;
        sample_next   = sample_reg;
        done          = 1'b0;

        if (!cfg.spi_enable)
        begin
            active_next   = 1'b0;
            edge_cnt_next = '0;
            div_cnt_next  = '0;
            sck_next      = cpol;
        end
        else if (!active_reg)
        begin
            if (item.command == spims_pkg::CMD_START)
            begin
                shift_next    = item.tx_byte;
                active_next   = 1'b1;
                edge_cnt_next = '0;
                div_cnt_next  = '0;
                sck_next      = cpol;
            end
        end
        else if (({1'b0, div_cnt_reg} + spims_pkg::HALF_W'(1)) >= half)
        begin
            // SCK edge
            div_cnt_next = '0;
            sck_next     = ~sck_reg;
            if (edge_cnt_reg[0] == cpha)
            begin
                sample_next = item.miso_bit;
                if (cpha && edge_cnt_reg == spims_pkg::EDGE_LAST)
                begin
                    shift_next = spims_pkg::shift_step(shift_reg, item.miso_bit,
                                                       cfg.lsb_first);
                end
            end
            else if (!(cpha && edge_cnt_reg == '0))
            begin
                shift_next = spims_pkg::shift_step(shift_reg, sample_reg, cfg.lsb_first);
            end
            edge_cnt_next = edge_inc;
            if (edge_inc >= spims_pkg::EDGE_TOTAL)
            begin
                active_next   = 1'b0;
                edge_cnt_next = '0;
                rcvd_next     = shift_next;
                done          = 1'b1;
                sck_next      = cpol;
            end
        end
        else
        begin
            div_cnt_next = div_cnt_reg + spims_pkg::DIV_W'(1);
        end
    end

    // Result as seen after this tick
    always_comb
    begin
        result.sck_level  = active_next ? sck_next : cpol;
        result.mosi_level = cfg.lsb_first ? shift_next[0]
                                          : shift_next[spims_pkg::DATA_BITS-1];
        result.busy_res   = active_next;
        result.done_res   = done;
        result.rx_byte    = rcvd_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg    <= '0;
            edge_cnt_reg <= '0;
            div_cnt_reg  <= '0;
            sck_reg      <= 1'b0;
            active_reg   <= 1'b0;
            rcvd_reg     <= '0;
            sample_reg   <= 1'b0;
        end
        else if (step)
        begin
            shift_reg    <= shift_next;
            edge_cnt_reg <= edge_cnt_next;
            div_cnt_reg  <= div_cnt_next;
            sck_reg      <= sck_next;
            active_reg   <= active_next;
            rcvd_reg     <= rcvd_next;
            sample_reg   <= sample_next;
        end
    end

    // Counters sit at zero whenever no transfer runs
    a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (edge_cnt_reg == '0 && div_cnt_reg == '0))
        else $error("counters not cleared while idle");

    // Edge count never reaches the transfer length in the register
    a_edge_range: assert property (@(posedge clk) disable iff (!rst_n)
        edge_cnt_reg < spims_pkg::EDGE_TOTAL)
        else $error("edge count out of range");

    // Divider stays below the longest half period
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_cnt_reg < spims_pkg::DIV_W'(64))
        else $error("divider count out of range");

endmodule

>>> rtl/spi_master_byte_shifter.sv
// Path: an accepted request is held in the input register, then its engine result
//   is loaded into the result register that drives the output channel.
// Throughput: one request per clock while the output channel is not stalled.
// Reset: rst_n clears the pipeline valids and transfer state at once; the
//   registers come up enabled, mode 0, MSB first, divide by 4.
// ----------------------------------------------------------------------------
// spi_master_byte_shifter
// SPI master engine, one system tick per request, modes 0-3, MSB/LSB first.
// ----------------------------------------------------------------------------
module spi_master_byte_shifter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  spims_pkg::in_item_t                  in_item,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output spims_pkg::out_item_t                 out_item,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [spims_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spims_pkg::CFG_DATA_W-1:0]     cfg_data
);

    spims_pkg::cfg_t      cfg;
    spims_pkg::in_item_t  item_reg;
    logic                 item_valid_reg;
    spims_pkg::out_item_t result;
    spims_pkg::out_item_t res_reg;
    logic                 res_valid_reg;
    logic                 advance;
    logic                 take;

    // Engine steps when the output register can take the result
    assign advance   = item_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall  = item_valid_reg && !advance;
    assign take      = in_valid && !in_stall;
    assign out_valid = res_valid_reg;
    assign out_item  = res_reg;

    spims_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spims_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .cfg    (cfg),
        .item   (item_reg),
        .result (result)
    );

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

    // A completed byte ends the transfer in the same result
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.done_res) |-> !res_reg.busy_res)
        else $error("done with busy still set");

    // Input stalls only with a held request waiting
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (item_valid_reg && res_valid_reg && out_stall))
        else $error("input stalled without backpressure");

    // A request in the input register moves on once the output frees up
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !out_stall && !in_valid) |=> !item_valid_reg)
        else $error("input register failed to drain");

endmodule
